// ===== hdl/smi_pkg.sv =====
// types and constants for the symmetric 3x3 inverse pipeline
// no dependencies
package smi_pkg;

   localparam int DataW = 32;               // entry and result width
   localparam int ProdW = 2 * DataW;        // one entry product
   localparam int CofW  = ProdW + 1;        // cofactor, signed
   localparam int DetW  = 3 * DataW + 1;    // determinant, signed
   localparam int DmW   = DetW - 1;         // determinant magnitude
   localparam int RemW  = DmW + DataW;      // divider remainder
   localparam int QuoW  = DataW;            // quotient bits produced
   localparam int NLane = 6;                // distinct inverse entries

   localparam logic [DataW-1:0] MaxPos = {1'b0, {(DataW-1){1'b1}}};
   localparam logic [DataW-1:0] MinNeg = {1'b1, {(DataW-1){1'b0}}};

   typedef struct packed {
      logic signed [DataW-1:0] m11;
      logic signed [DataW-1:0] m21;
      logic signed [DataW-1:0] m31;
      logic signed [DataW-1:0] m12;
      logic signed [DataW-1:0] m22;
      logic signed [DataW-1:0] m32;
      logic signed [DataW-1:0] m13;
      logic signed [DataW-1:0] m23;
      logic signed [DataW-1:0] m33;
   } req_type;

   typedef struct packed {
      logic signed [DataW-1:0] inv11;
      logic signed [DataW-1:0] inv12;
      logic signed [DataW-1:0] inv13;
      logic signed [DataW-1:0] inv22;
      logic signed [DataW-1:0] inv23;
      logic signed [DataW-1:0] inv33;
      logic                    singular;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [DataW-1:0]      a11;
      logic signed [DataW-1:0]      a21;
      logic signed [DataW-1:0]      a31;
      logic [2:0][CofW-1:0]         dc;
      logic [NLane-1:0][CofW-1:0]   c;
   } front_type;

   typedef struct packed {
      logic [DetW-1:0]              det;
      logic [NLane-1:0][CofW-1:0]   c;
   } det_type;

   typedef struct packed {
      logic [NLane-1:0][RemW-1:0]   rem;
      logic [NLane-1:0][QuoW-1:0]   quo;
      logic [NLane-1:0]             neg;
      logic [NLane-1:0]             over;
      logic [DmW-1:0]               dm;
      logic                         sing;
   } div_item_type;

endpackage

// ===== hdl/symmetric_matrix3x3_inverse.sv =====
// Inverse of a symmetric 3x3 matrix in signed fixed point.
// Request channel req_valid/req_ready/req_data carries the nine entries,
// result channel rsp_valid/rsp_ready/rsp_data the six distinct inverse
// entries plus singular and saturated flags. Entries carry FRAC_BITS
// fraction bits. The determinant uses the whole matrix, the cofactors
// only the upper triangle.
// From an accepted item to rsp_valid an item passes the product and
// cofactor stages, the determinant stages, the magnitude and range-check
// stages, 32 one-bit division steps and one output register.
// Throughput is one item per cycle while the pipeline is not stalled; the
// 32 division steps each hold one item, so up to 40 items are in flight.
// Reset clears all valid bits; the pipeline is empty after it.
// When the receiver stalls, the output register holds its item and the
// pipeline keeps moving while its last stage is empty, so bubbles close
// up; once the last stage holds an item too, req_ready drops.
// depends on smi_pkg, smi_front, smi_det, smi_div_step
module symmetric_matrix3x3_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  smi_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output smi_pkg::rsp_type   rsp_data
);
   import smi_pkg::*;

   localparam int Shift = 2 * FRAC_BITS;

   logic                      en;
   logic                      front_valid, det_valid;
   front_type                 front_data;
   det_type                   det_data;

   logic [DetW-1:0]           dabs;
   logic [CofW-1:0]           cabs [NLane];
   logic [NLane-1:0][RemW-1:0] nm_in, nm_ff;
   logic [NLane-1:0]          neg_in, neg_ff;
   logic [DmW-1:0]            dm_ff;
   logic                      sing_ff, valid_f_ff;
   div_item_type              first_in, first_ff;
   logic                      valid_g_ff;

   div_item_type              stage_item [QuoW+1];
   logic [QuoW:0]             stage_valid;

   logic [NLane-1:0][DataW-1:0] val;
   logic [NLane-1:0]          sat;
   rsp_type                   rsp_in, rsp_ff;
   logic                      rsp_valid_ff;

   // stall only when the output is held and the last stage is full
   assign en        = !(rsp_valid_ff && !rsp_ready && stage_valid[QuoW]);
   assign req_ready = en;

   smi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   smi_det u_det (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (det_valid),
      .out_data  (det_data)
   );

   // magnitudes and signs
   always_comb begin
      dabs = det_data.det[DetW-1] ? DetW'(-det_data.det) : det_data.det;
      for (int k = 0; k < NLane; k++) begin
         cabs[k]   = det_data.c[k][CofW-1] ? CofW'(-det_data.c[k]) : det_data.c[k];
         nm_in[k]  = RemW'(cabs[k][CofW-2:0]) << Shift;
         neg_in[k] = det_data.c[k][CofW-1] ^ det_data.det[DetW-1];
      end
   end

   // quotient fits 32 bits only if the numerator is below dm * 2^32
   always_comb begin
      first_in.rem  = nm_ff;
      first_in.quo  = '0;
      first_in.neg  = neg_ff;
      first_in.dm   = dm_ff;
      first_in.sing = sing_ff;
      for (int k = 0; k < NLane; k++) begin
         first_in.over[k] = nm_ff[k] >= {dm_ff, {QuoW{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nm_ff    <= nm_in;
         neg_ff   <= neg_in;
         dm_ff    <= dabs[DmW-1:0];
         sing_ff  <= (det_data.det == '0);
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f_ff <= 1'b0;
         valid_g_ff <= 1'b0;
      end else if (en) begin
         valid_f_ff <= det_valid;
         valid_g_ff <= valid_f_ff;
      end
   end

   assign stage_item[0]  = first_ff;
   assign stage_valid[0] = valid_g_ff;

   for (genvar i = 0; i < QuoW; i++) begin : g_div
      smi_div_step #(.STEP(QuoW - 1 - i)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stage_valid[i]),
         .in_item   (stage_item[i]),
         .out_valid (stage_valid[i+1]),
         .out_item  (stage_item[i+1])
      );
   end

   // sign, clamp and singular override
   always_comb begin
      for (int k = 0; k < NLane; k++) begin
         if (stage_item[QuoW].neg[k]) begin
            sat[k] = stage_item[QuoW].over[k] || (stage_item[QuoW].quo[k] > MinNeg);
            val[k] = sat[k] ? MinNeg : DataW'(-stage_item[QuoW].quo[k]);
         end else begin
            sat[k] = stage_item[QuoW].over[k] || stage_item[QuoW].quo[k][QuoW-1];
            val[k] = sat[k] ? MaxPos : stage_item[QuoW].quo[k];
         end
      end
      if (stage_item[QuoW].sing) begin
         rsp_in = '0;
         rsp_in.singular = 1'b1;
      end else begin
         rsp_in.inv11     = val[0];
         rsp_in.inv12     = val[1];
         rsp_in.inv13     = val[2];
         rsp_in.inv22     = val[3];
         rsp_in.inv23     = val[4];
         rsp_in.inv33     = val[5];
         rsp_in.singular  = 1'b0;
         rsp_in.saturated = |sat;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= stage_valid[QuoW];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.singular |->
         rsp_ff.inv11 == '0 && rsp_ff.inv12 == '0 && rsp_ff.inv13 == '0 &&
         rsp_ff.inv22 == '0 && rsp_ff.inv23 == '0 && rsp_ff.inv33 == '0 &&
         !rsp_ff.saturated)
      else $error("singular item with nonzero payload");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.saturated |->
         rsp_ff.inv11 == MaxPos || rsp_ff.inv11 == MinNeg ||
         rsp_ff.inv12 == MaxPos || rsp_ff.inv12 == MinNeg ||
         rsp_ff.inv13 == MaxPos || rsp_ff.inv13 == MinNeg ||
         rsp_ff.inv22 == MaxPos || rsp_ff.inv22 == MinNeg ||
         rsp_ff.inv23 == MaxPos || rsp_ff.inv23 == MinNeg ||
         rsp_ff.inv33 == MaxPos || rsp_ff.inv33 == MinNeg)
      else $error("saturated flag without a clamped entry");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready && stage_valid[QuoW])
      else $error("input stalled while output could drain");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("held result item changed");

endmodule

// ===== hdl/smi_front.sv =====
// entry products and 2x2 cofactors, two register stages
// depends on smi_pkg
module smi_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  smi_pkg::req_type      in_data,
   output logic                  out_valid,
   output smi_pkg::front_type    out_data
);
   import smi_pkg::*;

   localparam int NProd = 14;

   logic signed [ProdW-1:0] prod_in [NProd];
   logic signed [ProdW-1:0] prod_ff [NProd];
   logic signed [DataW-1:0] a11_ff, a21_ff, a31_ff;
   logic                    valid_a_ff;
   front_type               front_in, front_ff;
   logic                    valid_b_ff;

   function automatic logic [CofW-1:0] sub2(input logic [ProdW-1:0] x,
                                            input logic [ProdW-1:0] y);
      return {x[ProdW-1], x} - {y[ProdW-1], y};
   endfunction

   always_comb begin
      prod_in[0]  = in_data.m22 * in_data.m33;
      prod_in[1]  = in_data.m32 * in_data.m23;
      prod_in[2]  = in_data.m32 * in_data.m13;
      prod_in[3]  = in_data.m12 * in_data.m33;
      prod_in[4]  = in_data.m12 * in_data.m23;
      prod_in[5]  = in_data.m22 * in_data.m13;
      prod_in[6]  = in_data.m23 * in_data.m23;
      prod_in[7]  = in_data.m13 * in_data.m23;
      prod_in[8]  = in_data.m11 * in_data.m33;
      prod_in[9]  = in_data.m13 * in_data.m13;
      prod_in[10] = in_data.m13 * in_data.m12;
      prod_in[11] = in_data.m11 * in_data.m23;
      prod_in[12] = in_data.m11 * in_data.m22;
      prod_in[13] = in_data.m12 * in_data.m12;
   end

   always_comb begin
      front_in.a11  = a11_ff;
      front_in.a21  = a21_ff;
      front_in.a31  = a31_ff;
      // determinant uses the full matrix
      front_in.dc[0] = sub2(prod_ff[0], prod_ff[1]);
      front_in.dc[1] = sub2(prod_ff[2], prod_ff[3]);
      front_in.dc[2] = sub2(prod_ff[4], prod_ff[5]);
      // inverse cofactors from the upper triangle only
      front_in.c[0] = sub2(prod_ff[0], prod_ff[6]);
      front_in.c[1] = sub2(prod_ff[7], prod_ff[3]);
      front_in.c[2] = sub2(prod_ff[4], prod_ff[5]);
      front_in.c[3] = sub2(prod_ff[8], prod_ff[9]);
      front_in.c[4] = sub2(prod_ff[10], prod_ff[11]);
      front_in.c[5] = sub2(prod_ff[12], prod_ff[13]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         a11_ff   <= in_data.m11;
         a21_ff   <= in_data.m21;
         a31_ff   <= in_data.m31;
         front_ff <= front_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_data  = front_ff;

endmodule

// ===== hdl/smi_det.sv =====
// determinant: split products, terms, sum; three register stages
// depends on smi_pkg
module smi_det (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  smi_pkg::front_type    in_data,
   output logic                  out_valid,
   output smi_pkg::det_type      out_data
);
   import smi_pkg::*;

   localparam int HiW = CofW - DataW;
   localparam int PW  = DataW + HiW;

   logic signed [DataW-1:0] a_k [3];
   logic signed [PW-1:0]    plo_in [3], phi_in [3];
   logic signed [PW-1:0]    plo_ff [3], phi_ff [3];
   logic [DetW-1:0]         term_in [3], term_ff [3];
   logic [NLane-1:0][CofW-1:0] c_c_ff, c_d_ff;
   det_type                 det_in, det_ff;
   logic [2:0]              valid_ff;

   assign a_k[0] = in_data.a11;
   assign a_k[1] = in_data.a21;
   assign a_k[2] = in_data.a31;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         // low half unsigned, high half signed
         plo_in[k] = a_k[k] * $signed({1'b0, in_data.dc[k][DataW-1:0]});
         phi_in[k] = a_k[k] * $signed(in_data.dc[k][CofW-1:DataW]);
         term_in[k] = DetW'({phi_ff[k], {DataW{1'b0}}})
                    + {{(DetW-PW){plo_ff[k][PW-1]}}, plo_ff[k]};
      end
      det_in.det = term_ff[0] + term_ff[1] + term_ff[2];
      det_in.c   = c_d_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         c_c_ff  <= in_data.c;
         term_ff <= term_in;
         c_d_ff  <= c_c_ff;
         det_ff  <= det_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = det_ff;

endmodule

// ===== hdl/smi_div_step.sv =====
// one restoring division step for all six lanes, one register stage
// depends on smi_pkg
module smi_div_step #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  smi_pkg::div_item_type   in_item,
   output logic                    out_valid,
   output smi_pkg::div_item_type   out_item
);
   import smi_pkg::*;

   logic [RemW-1:0] dsh;
   div_item_type    item_in, item_ff;
   logic            valid_ff;

   assign dsh = RemW'(in_item.dm) << STEP;

   always_comb begin
      item_in = in_item;
      for (int k = 0; k < NLane; k++) begin
         if (in_item.rem[k] >= dsh) begin
            item_in.rem[k]       = in_item.rem[k] - dsh;
            item_in.quo[k][STEP] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== dv/tb.sv =====
// testbench for symmetric_matrix3x3_inverse: drives matrices, predicts the
// inverse entries with wide exact arithmetic and checks every result item
// depends on smi_pkg and the block's rtl
`timescale 1ns / 100ps

module tb;
   import smi_pkg::*;

   localparam int FracBits = 16;
   localparam int HoldCycles = 300;
   localparam longint unsigned CycleLimit = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type inverse_queue[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   bit      hold_off = 1'b0;
   bit      failed = 1'b0;
   longint unsigned cycle_count = 0;

   symmetric_matrix3x3_inverse #(.FRAC_BITS(FracBits)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // quotient toward zero, clamped to the signed result range
   function automatic logic [DataW-1:0] clamp_quot(logic signed [255:0] cof,
         logic signed [255:0] det, inout bit sat);
      logic signed [255:0] num;
      logic signed [255:0] q;
      num = cof <<< (2 * FracBits);
      q = num / det;
      if (q > 256'sd2147483647) begin
         sat = 1'b1;
         return MaxPos;
      end
      if (q < -256'sd2147483648) begin
         sat = 1'b1;
         return MinNeg;
      end
      return q[DataW-1:0];
   endfunction

   function automatic rsp_type invert_matrix(req_type m);
      logic signed [255:0] a11, a21, a31, a12, a22, a32, a13, a23, a33, det;
      rsp_type r;
      bit sat;
      a11 = m.m11; a21 = m.m21; a31 = m.m31;
      a12 = m.m12; a22 = m.m22; a32 = m.m32;
      a13 = m.m13; a23 = m.m23; a33 = m.m33;
      sat = 1'b0;
      r = '0;
      det = a11 * (a22 * a33 - a32 * a23) + a21 * (a32 * a13 - a12 * a33)
          + a31 * (a12 * a23 - a22 * a13);
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      r.inv11 = clamp_quot(a22 * a33 - a23 * a23, det, sat);
      r.inv12 = clamp_quot(a13 * a23 - a12 * a33, det, sat);
      r.inv13 = clamp_quot(a12 * a23 - a13 * a22, det, sat);
      r.inv22 = clamp_quot(a11 * a33 - a13 * a13, det, sat);
      r.inv23 = clamp_quot(a13 * a12 - a11 * a23, det, sat);
      r.inv33 = clamp_quot(a11 * a22 - a12 * a12, det, sat);
      r.saturated = sat;
      return r;
   endfunction

   // valid stays up after an accept; idle cycles and wait_drained drop it
   task automatic send_matrix(req_type m);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= m;
      inverse_queue.push_back(invert_matrix(m));
      do @(posedge clock); while (!req_ready);
   endtask

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (inverse_queue.size() == 0) begin
            $display("%0t unexpected item: actual %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            rsp_type want;
            want = inverse_queue.pop_front();
            if (rsp_data.inv11 !== want.inv11) begin
               $display("%0t inv11 expected %h actual %h", $time, want.inv11, rsp_data.inv11);
               failed = 1'b1;
            end
            if (rsp_data.inv12 !== want.inv12) begin
               $display("%0t inv12 expected %h actual %h", $time, want.inv12, rsp_data.inv12);
               failed = 1'b1;
            end
            if (rsp_data.inv13 !== want.inv13) begin
               $display("%0t inv13 expected %h actual %h", $time, want.inv13, rsp_data.inv13);
               failed = 1'b1;
            end
            if (rsp_data.inv22 !== want.inv22) begin
               $display("%0t inv22 expected %h actual %h", $time, want.inv22, rsp_data.inv22);
               failed = 1'b1;
            end
            if (rsp_data.inv23 !== want.inv23) begin
               $display("%0t inv23 expected %h actual %h", $time, want.inv23, rsp_data.inv23);
               failed = 1'b1;
            end
            if (rsp_data.inv33 !== want.inv33) begin
               $display("%0t inv33 expected %h actual %h", $time, want.inv33, rsp_data.inv33);
               failed = 1'b1;
            end
            if (rsp_data.singular !== want.singular) begin
               $display("%0t singular expected %b actual %b", $time, want.singular,
                  rsp_data.singular);
               failed = 1'b1;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $display("%0t saturated expected %b actual %b", $time, want.saturated,
                  rsp_data.saturated);
               failed = 1'b1;
            end
         end
      end
   end

   // receiver ready, with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   function automatic logic [DataW-1:0] rand_entry();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(4) << FracBits;
         2: return -($urandom_range(4) << FracBits);
         3: return $urandom_range(255) - 128;
         4: return {$urandom} >>> $urandom_range(28);
         default: return ($urandom_range(9) - 4) <<< (FracBits - 3);
      endcase
   endfunction

   function automatic req_type rand_matrix();
      req_type m;
      m.m11 = rand_entry(); m.m12 = rand_entry(); m.m13 = rand_entry();
      m.m22 = rand_entry(); m.m23 = rand_entry(); m.m33 = rand_entry();
      // mostly symmetric, sometimes not
      if ($urandom_range(9) < 8) begin
         m.m21 = m.m12; m.m31 = m.m13; m.m32 = m.m23;
      end else begin
         m.m21 = rand_entry(); m.m31 = rand_entry(); m.m32 = rand_entry();
      end
      // sometimes force a singular matrix: row 3 equals row 1
      if ($urandom_range(19) == 0) begin
         m.m31 = m.m11; m.m32 = m.m12; m.m33 = m.m13;
      end
      return m;
   endfunction

   function automatic req_type sym3(logic [31:0] d1, logic [31:0] d2, logic [31:0] d3,
         logic [31:0] o12, logic [31:0] o13, logic [31:0] o23);
      req_type m;
      m.m11 = d1; m.m22 = d2; m.m33 = d3;
      m.m12 = o12; m.m21 = o12; m.m13 = o13; m.m31 = o13; m.m23 = o23; m.m32 = o23;
      return m;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (inverse_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      localparam logic [31:0] One = 32'h0001_0000;
      send_matrix(sym3(One, One, One, 0, 0, 0));
      send_matrix(sym3(2 * One, 4 * One, -One, One, 0, One / 2));
      send_matrix('0);
      send_matrix(sym3(One, One, One, One, One, One));
      send_matrix(sym3(1, 1, 1, 0, 0, 0));
      send_matrix(sym3(-1, -1, -1, 0, 0, 0));
      send_matrix(sym3(MaxPos, MaxPos, MaxPos, 0, 0, 0));
      send_matrix(sym3(MinNeg, MinNeg, MinNeg, 0, 0, 0));
      send_matrix(sym3(MinNeg, MinNeg, MinNeg, MinNeg, MinNeg, MinNeg));
      send_matrix(sym3(MaxPos, MinNeg, MaxPos, MinNeg, MaxPos, MinNeg));
      send_matrix(sym3(32'hFFFF_FFFF, MaxPos, 1, MinNeg, 32'hFFFF_FFFF, 1));
      send_matrix(sym3(One, One, One, One / 2, One / 4, One / 8));
      send_matrix(sym3(-One, -One, -One, 0, 0, 0));
      send_matrix(sym3(One, One, 2 * One, One, 0, 0));
      send_matrix({One, MaxPos, MinNeg, 32'd0, One, 32'hAAAA_AAAA, 32'd0, 32'd0, One});
      send_matrix({One, 32'd0, 32'd0, 32'h5555_5555, One, 32'd0, 32'd0, 32'd0, One});
      send_matrix({32'd0, One, 32'd0, One, 32'd0, 32'd0, 32'd0, 32'd0, One});
      wait_drained();
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_matrix(rand_matrix());
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      int held;
      hold_off = 1'b1;
      fork
         begin
            for (held = 0; held < HoldCycles; held++) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (80) send_matrix(rand_matrix());
      join
      wait_drained();
      // sender pauses until all results are back
      repeat (5) send_matrix(rand_matrix());
      wait_drained();
      repeat (5) send_matrix(rand_matrix());
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150, 0, 0);
      test_random(120, 68, 0);
      test_random(120, 0, 68);
      test_random(120, 8, 8);
      test_backpressure();
      repeat (60) @(posedge clock);
      if (!failed && inverse_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
